// ===== design/ccl_pkg.sv =====
// Shared types, constants and preset table for the credential check core.
// No dependencies; imported by the top level and the testbench.
package ccl_pkg;

   // Field widths
   localparam int ID_W     = 48;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = 4;
   localparam int LIMIT_W  = 4;
   localparam int STATUS_W = 3;

   // Preset users loaded by the sweep after reset
   localparam int PRESET_COUNT = 5;
   localparam int PRESET_IDX_W = 3;
   localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

   // Request kinds (carried on tuser)
   localparam logic ACT_VERIFY = 1'b0;
   localparam logic ACT_CHANGE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STS_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] STS_WRONG_KEY = 3'd1;
   localparam logic [STATUS_W-1:0] STS_BLOCKED   = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STS_CHANGED   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_NO_ID     = 3'd5;

   // One table entry as stored in the RAM
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] fails;
      logic             locked;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Preset IDs, first character in the top byte
   function automatic logic [ID_W-1:0] preset_id(input logic [PRESET_IDX_W-1:0] idx);
      logic [ID_W-1:0] val;
      case (idx)
         3'd0:    val = 48'h313233343536; // "123456"
         3'd1:    val = 48'h363534333231; // "654321"
         3'd2:    val = 48'h414243443132; // "ABCD12"
         3'd3:    val = 48'h414243443334; // "ABCD34"
         3'd4:    val = 48'h393837363534; // "987654"
         default: val = '0;
      endcase
      return val;
   endfunction

   // Preset keys
   function automatic logic [KEY_W-1:0] preset_key(input logic [PRESET_IDX_W-1:0] idx);
      logic [KEY_W-1:0] val;
      case (idx)
         3'd1:                   val = 32'h34333231; // "4321"
         3'd0, 3'd2, 3'd3, 3'd4: val = 32'h31323334; // "1234"
         default:                val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/ccl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/credential_check_with_lockout_core.sv =====
// Top level of the credential check core: request FSM, table scan, update.
// Depends on ccl_pkg and ccl_ram.
//
// Keeps a table of USER_SLOTS users in one RAM (ID, key, failed count, blocked
// flag). After reset the block loads the five preset users and zeroes the
// other slots; req_tready stays low meanwhile, while csr writes are taken at
// any time. After a request beat is accepted, the scan reads one table slot per
// cycle through the registered RAM read port; a hit ends the scan at that slot
// and a miss scans every slot. The next request beat is taken the cycle after
// the result is loaded into the output register. The matched entry is written
// back in the cycle it is compared. Slots beyond the five presets never match.
module credential_check_with_lockout_core
   import ccl_pkg::*;
#(
   parameter int USER_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // [47:0] user_id, [79:48] user_key
   input  logic        req_tuser,   // [0] action
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] granted, [3:1] status, [7:4] zero
   // configuration
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data  // attempt_limit
);

   localparam int ADDR_W = $clog2(USER_SLOTS);
   localparam int CNT_IW = ADDR_W + 1;
   localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(USER_SLOTS - 1);
   localparam logic [CNT_IW-1:0] SLOTS_CNT  = CNT_IW'(USER_SLOTS);
   localparam logic [ADDR_W-1:0] PRESET_END = ADDR_W'(PRESET_COUNT);

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    init_idx_ff, init_idx_in;
   logic [CNT_IW-1:0]    issue_idx_ff, issue_idx_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                 action_ff, action_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 pend_granted_ff, pend_granted_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   entry_type            wr_entry;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   entry_type            rd_entry;

   logic                 req_fire;
   logic                 slot_valid;
   logic                 hit;
   logic [CNT_W-1:0]     fails_sat;
   logic                 out_free;

   // user table
   ccl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (USER_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);
   assign rd_addr  = issue_idx_ff[ADDR_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // compare of the slot whose read data is now out of the RAM
   assign slot_valid = (chk_idx_ff < PRESET_END);
   assign hit = chk_valid_ff && slot_valid && (rd_entry.id == id_ff) &&
                ((action_ff == ACT_CHANGE) || !rd_entry.locked);
   assign fails_sat = (rd_entry.fails == CNT_MAX) ? CNT_MAX : rd_entry.fails + 1'b1;

   // next-state and datapath
   always_comb begin
      state_in        = state_ff;
      init_idx_in     = init_idx_ff;
      issue_idx_in    = issue_idx_ff;
      chk_valid_in    = 1'b0;
      chk_idx_in      = chk_idx_ff;
      action_in       = action_ff;
      id_in           = id_ff;
      key_in          = key_ff;
      pend_granted_in = pend_granted_ff;
      pend_status_in  = pend_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_granted_in  = rsp_granted_ff;
      rsp_status_in   = rsp_status_ff;
      limit_in        = csr_wr_en ? csr_wr_data : limit_ff;
      wr_en           = 1'b0;
      wr_addr         = chk_idx_ff;
      wr_entry        = rd_entry;

      unique case (state_ff)
         // load presets and zero the other slots, one slot per cycle
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_idx_ff;
            if (init_idx_ff < PRESET_END) begin
               wr_entry.id  = preset_id(init_idx_ff[PRESET_IDX_W-1:0]);
               wr_entry.key = preset_key(init_idx_ff[PRESET_IDX_W-1:0]);
            end else begin
               wr_entry.id  = '0;
               wr_entry.key = '0;
            end
            wr_entry.fails  = '0;
            wr_entry.locked = 1'b0;
            init_idx_in = init_idx_ff + 1'b1;
            if (init_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               action_in    = req_tuser;
               id_in        = req_tdata[ID_W-1:0];
               key_in       = req_tdata[ID_W+KEY_W-1:ID_W];
               issue_idx_in = '0;
               state_in     = S_SCAN;
            end
         end

         // issue one read per cycle, check the previous one
         S_SCAN: begin
            if (issue_idx_ff < SLOTS_CNT) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_idx_ff[ADDR_W-1:0];
               issue_idx_in = issue_idx_ff + 1'b1;
            end
            if (hit) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
               if (action_ff == ACT_CHANGE) begin
                  wr_entry.key    = key_ff;
                  pend_granted_in = 1'b0;
                  pend_status_in  = STS_CHANGED;
               end else if (rd_entry.key == key_ff) begin
                  wr_entry.fails  = '0;
                  pend_granted_in = 1'b1;
                  pend_status_in  = STS_GRANTED;
               end else begin
                  wr_entry.fails  = fails_sat;
                  pend_granted_in = 1'b0;
                  if (fails_sat >= limit_ff) begin
                     wr_entry.locked = 1'b1;
                     pend_status_in  = STS_BLOCKED;
                  end else begin
                     pend_status_in  = STS_WRONG_KEY;
                  end
               end
            end else if (chk_valid_ff && (chk_idx_ff == LAST_IDX)) begin
               state_in        = S_DONE;
               pend_granted_in = 1'b0;
               pend_status_in  = (action_ff == ACT_CHANGE) ? STS_NO_ID : STS_NOT_FOUND;
            end
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = pend_granted_ff;
               rsp_status_in  = pend_status_ff;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_idx_ff  <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         init_idx_ff  <= init_idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
      issue_idx_ff    <= issue_idx_in;
      chk_idx_ff      <= chk_idx_in;
      action_ff       <= action_in;
      id_ff           <= id_in;
      key_ff          <= key_in;
      pend_granted_ff <= pend_granted_in;
      pend_status_ff  <= pend_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_status_ff, rsp_granted_ff};

endmodule

// ===== verif/tb_credential_check_with_lockout_core.sv =====
// Self-checking testbench for credential_check_with_lockout_core.
// Needs ccl_pkg and the core RTL; a directed part, then random traffic at
// several attempt limits, is checked against a table-based predictor.
`timescale 1ns / 1ps

module tb_credential_check_with_lockout_core
   import ccl_pkg::*;
();

   localparam int USER_SLOTS = 8;
   localparam int PRESETS    = 5;

   // Preset IDs and keys, first character in the top byte
   localparam logic [ID_W-1:0]  UID_123456 = 48'h313233343536;
   localparam logic [ID_W-1:0]  UID_654321 = 48'h363534333231;
   localparam logic [ID_W-1:0]  UID_ABCD12 = 48'h414243443132;
   localparam logic [ID_W-1:0]  UID_ABCD34 = 48'h414243443334;
   localparam logic [ID_W-1:0]  UID_987654 = 48'h393837363534;
   localparam logic [KEY_W-1:0] KEY_1234   = 32'h31323334;
   localparam logic [KEY_W-1:0] KEY_4321   = 32'h34333231;

   typedef struct {
      logic             act;
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } login_req_type;

   typedef struct packed {
      logic                granted;
      logic [STATUS_W-1:0] status;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // [47:0] user_id, [79:48] user_key
   logic        req_tuser = 1'b0; // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] granted, [3:1] status, [7:4] zero
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   credential_check_with_lockout_core #(
      .USER_SLOTS(USER_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Predicted user table and limit
   logic [ID_W-1:0]    usr_id     [USER_SLOTS];
   logic [KEY_W-1:0]   usr_key    [USER_SLOTS];
   logic [CNT_W-1:0]   usr_fails  [USER_SLOTS];
   logic               usr_locked [USER_SLOTS];
   logic               usr_valid  [USER_SLOTS];
   logic [LIMIT_W-1:0] fail_limit;

   // Keys as issued by the stimulus, tracked at queueing time
   logic [KEY_W-1:0]   issued_key [PRESETS];

   login_req_type request_q[$];
   verdict_type   pending_verdicts[$];

   int errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_limit_writes = 0;
   int n_granted = 0, n_wrong = 0, n_blocked = 0, n_refused = 0;
   int n_changed = 0, n_no_id = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_count = 0;

   // Clock and reset
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit
   initial begin
      #500000;
      $display("credential_check_with_lockout_core regression: fail");
      $finish;
   end

   // Table state after reset
   task automatic clear_table();
      for (int i = 0; i < USER_SLOTS; i++) begin
         usr_id[i]     = '0;
         usr_key[i]    = '0;
         usr_fails[i]  = '0;
         usr_locked[i] = 1'b0;
         usr_valid[i]  = (i < PRESETS);
      end
      usr_id[0] = UID_123456;
      usr_id[1] = UID_654321;
      usr_id[2] = UID_ABCD12;
      usr_id[3] = UID_ABCD34;
      usr_id[4] = UID_987654;
      usr_key[0] = KEY_1234;
      usr_key[1] = KEY_4321;
      usr_key[2] = KEY_1234;
      usr_key[3] = KEY_1234;
      usr_key[4] = KEY_1234;
      for (int i = 0; i < PRESETS; i++) issued_key[i] = usr_key[i];
      fail_limit = LIMIT_RESET;
   endtask

   // Applies one request to the predicted table and returns its verdict
   function automatic verdict_type judge_request(input logic act, input logic [ID_W-1:0] id,
                                                 input logic [KEY_W-1:0] key);
      verdict_type v;
      logic        hit;
      v.granted = 1'b0;
      hit = 1'b0;
      if (act == ACT_VERIFY) begin
         v.status = STS_NOT_FOUND;
         for (int i = 0; i < USER_SLOTS; i++) begin
            if (!hit && usr_valid[i] && !usr_locked[i] && usr_id[i] == id) begin
               hit = 1'b1;
               if (usr_key[i] == key) begin
                  usr_fails[i] = '0;
                  v.granted = 1'b1;
                  v.status = STS_GRANTED;
               end else begin
                  // count saturates, never wraps
                  if (usr_fails[i] != CNT_MAX) usr_fails[i] = usr_fails[i] + 1'b1;
                  if (usr_fails[i] >= fail_limit) begin
                     usr_locked[i] = 1'b1;
                     v.status = STS_BLOCKED;
                  end else begin
                     v.status = STS_WRONG_KEY;
                  end
               end
            end
         end
      end else begin
         // key change ignores the blocked flag
         v.status = STS_NO_ID;
         for (int i = 0; i < USER_SLOTS; i++) begin
            if (!hit && usr_valid[i] && usr_id[i] == id) begin
               hit = 1'b1;
               usr_key[i] = key;
               v.status = STS_CHANGED;
            end
         end
      end
      case (v.status)
         STS_GRANTED:   n_granted++;
         STS_WRONG_KEY: n_wrong++;
         STS_BLOCKED:   n_blocked++;
         STS_NOT_FOUND: n_refused++;
         STS_CHANGED:   n_changed++;
         default:       n_no_id++;
      endcase
      return v;
   endfunction

   // Request driver: bursts with random gaps, holds each beat until taken
   always @(posedge clock) begin : request_driver
      login_req_type nxt;
      verdict_type   v;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            v = judge_request(req_tuser, req_tdata[47:0], req_tdata[79:48]);
            pending_verdicts.push_back(v);
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
               nxt = request_q.pop_front();
               req_tdata  <= {nxt.key, nxt.id};
               req_tuser  <= nxt.act;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with its own stall pattern
   always @(posedge clock) begin : result_monitor
      verdict_type exp_v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               errors++;
               $display("%0t: result beat with none expected, tdata %h", $realtime, rsp_tdata);
            end else begin
               exp_v = pending_verdicts.pop_front();
               n_checked++;
               if (rsp_tdata[0] !== exp_v.granted) begin
                  errors++;
                  $display("%0t: granted mismatch, expected %0b, actual %0b",
                           $realtime, exp_v.granted, rsp_tdata[0]);
               end
               if (rsp_tdata[3:1] !== exp_v.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $realtime, exp_v.status, rsp_tdata[3:1]);
               end
               if (rsp_tdata[7:4] !== 4'h0) begin
                  errors++;
                  $display("%0t: pad bits mismatch, expected 0, actual %h",
                           $realtime, rsp_tdata[7:4]);
               end
            end
         end
         // switch stall mode when the stall counter wraps: always ready, coin flip, sparse
         if (stall_count == 63) begin
            stall_count = 0;
            stall_mode = $urandom_range(0, 2);
         end else begin
            stall_count++;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Queue one request; track the key a change leaves behind
   task automatic queue_req(input logic act, input logic [ID_W-1:0] id,
                            input logic [KEY_W-1:0] key);
      login_req_type r;
      r.act = act;
      r.id  = id;
      r.key = key;
      if (act == ACT_CHANGE) begin
         for (int i = 0; i < PRESETS; i++) if (usr_id[i] == id) issued_key[i] = key;
      end
      request_q.push_back(r);
   endtask

   // Wait until every request is answered, then let the core settle
   task automatic drain();
      @(negedge clock);
      while (request_q.size() != 0 || req_tvalid || pending_verdicts.size() != 0)
         @(negedge clock);
      repeat (USER_SLOTS + 4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] lim);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      fail_limit = lim;
      n_limit_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random traffic: mostly well-formed logins on preset users, some noise
   task automatic run_random_phase(input logic [LIMIT_W-1:0] lim, input int count);
      int r, slot;
      logic [ID_W-1:0]  rid;
      logic [KEY_W-1:0] rkey;
      write_limit(lim);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         slot = $urandom_range(0, PRESETS - 1);
         rid = usr_id[slot];
         rkey = $urandom;
         if (r < 50) begin
            queue_req(ACT_VERIFY, rid, issued_key[slot]);
         end else if (r < 65) begin
            // wrong key: near miss or unrelated
            if ($urandom_range(0, 1) == 0)
               rkey = issued_key[slot] ^ (32'd1 << $urandom_range(0, 31));
            else if (rkey == issued_key[slot])
               rkey = rkey ^ 32'd1;
            queue_req(ACT_VERIFY, rid, rkey);
         end else if (r < 78) begin
            if ($urandom_range(0, 3) == 0) rkey = ($urandom_range(0, 1) == 0) ? KEY_1234 : '0;
            queue_req(ACT_CHANGE, rid, rkey);
         end else if (r < 86) begin
            // unknown ID: fully random or one bit off a preset
            if ($urandom_range(0, 1) == 0) begin
               rid[47:32] = 16'($urandom_range(0, 65535));
               rid[31:0]  = $urandom;
            end else begin
               rid = rid ^ (48'd1 << $urandom_range(0, 47));
            end
            queue_req(ACT_VERIFY, rid, rkey);
         end else if (r < 90) begin
            queue_req(ACT_VERIFY, '0, ($urandom_range(0, 1) == 0) ? '0 : rkey);
         end else if (r < 95) begin
            if ($urandom_range(0, 1) == 0) rid = '0;
            else rid = rid ^ (48'd1 << $urandom_range(0, 47));
            queue_req(ACT_CHANGE, rid, rkey);
         end else begin
            queue_req(ACT_VERIFY, rid, rkey);
         end
      end
      drain();
   endtask

   // Main sequence
   initial begin
      clear_table();
      @(negedge clock);
      while (reset) @(negedge clock);
      write_limit(4'd3);

      // Directed: grants, wrong key and recovery, empty slots, key changes, lockout
      queue_req(ACT_VERIFY, UID_123456, KEY_1234);
      queue_req(ACT_VERIFY, UID_654321, KEY_4321);
      queue_req(ACT_VERIFY, UID_654321, KEY_1234);
      queue_req(ACT_VERIFY, UID_654321, KEY_4321);
      queue_req(ACT_VERIFY, '0, '0);
      queue_req(ACT_VERIFY, '1, '1);
      queue_req(ACT_CHANGE, '0, '1);
      queue_req(ACT_CHANGE, '1, '0);
      queue_req(ACT_VERIFY, UID_ABCD34, '0);
      queue_req(ACT_VERIFY, UID_ABCD34, '1);
      queue_req(ACT_VERIFY, UID_ABCD34, KEY_1234 + 1'b1);
      queue_req(ACT_VERIFY, UID_ABCD34, KEY_1234);
      // key change still lands on a blocked user, which stays blocked
      queue_req(ACT_CHANGE, UID_ABCD34, '1);
      queue_req(ACT_VERIFY, UID_ABCD34, '1);
      queue_req(ACT_CHANGE, UID_987654, '0);
      queue_req(ACT_VERIFY, UID_987654, '0);
      queue_req(ACT_VERIFY, UID_987654, KEY_1234);
      queue_req(ACT_VERIFY, UID_987654, '0);
      queue_req(ACT_VERIFY, UID_ABCD12, KEY_4321);
      queue_req(ACT_VERIFY, UID_ABCD12, KEY_4321);
      drain();

      // Lowered limit: a count already at the new limit blocks on the next miss
      write_limit(4'd2);
      queue_req(ACT_VERIFY, UID_ABCD12, '0);
      queue_req(ACT_VERIFY, UID_ABCD12, KEY_1234);
      drain();

      // Random phases, loosest limit first so users survive longer
      run_random_phase(4'd15, 200);
      run_random_phase(4'd9, 140);
      run_random_phase(4'd5, 110);
      run_random_phase(4'd1, 45);
      // out-of-range zero limit: first miss blocks
      run_random_phase(4'd0, 30);

      $display("summary: %0d requests sent, %0d results checked, %0d limit writes",
               n_accepted, n_checked, n_limit_writes);
      $display("summary: granted %0d, wrong key %0d, blocked %0d, refused %0d,",
               n_granted, n_wrong, n_blocked, n_refused);
      $display("summary: changed %0d, no ID %0d", n_changed, n_no_id);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("credential_check_with_lockout_core regression: pass");
      end else begin
         $display("credential_check_with_lockout_core regression: fail");
      end
      $finish;
   end

endmodule
